@@ src/obpt_pkg.sv @@
// Shared types and constants for the oriented box point test block.
// No dependencies; imported by every module of the block.
package obpt_pkg;

    // Width of the slack register, fixed by the register map.
    localparam int TOL_WIDTH = 19;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_ROW0   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_ROW1   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_ROW2   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NEG_CENTER = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_SIZE   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOLERANCE  = 3'd5;

    // Load enables of the pipeline stages inside the per-axis datapath.
    typedef struct packed {
        logic prod;   // product stage
        logic sum;    // sum stage
        logic cmp;    // compare stage
    } obpt_stage_en_t;

endpackage

@@ src/oriented_box_point_test_unit.sv @@
// Oriented box point test: one 3D point per transaction in, one inside flag per transaction out.
// The flag appears on the output after the input register (loaded at the accepting edge),
// then the product, sum, compare and output registers; throughput is one point per cycle
// while the output is not stalled, set by the fully pipelined multiply, add and compare
// stages, each 3x3 coefficient with its own multiplier.
// Reset (rst_n, asynchronous, active low) empties the pipeline and clears every configuration
// register to zero; with all-zero configuration every point reports inside.
module oriented_box_point_test_unit #(
    parameter int COORD_WIDTH = 20,
    parameter int COEF_WIDTH  = 18,
    localparam int IN_TDATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8,
    localparam int CFG_WIDTH_A    = (3 * COEF_WIDTH > 3 * COORD_WIDTH) ?
                                    3 * COEF_WIDTH : 3 * COORD_WIDTH,
    localparam int CFG_WIDTH      = (CFG_WIDTH_A > obpt_pkg::TOL_WIDTH) ?
                                    CFG_WIDTH_A : obpt_pkg::TOL_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input points. tdata fields from bit 0 up: point_x, point_y, point_z (signed,
    // COORD_WIDTH bits each), zero fill to a whole byte.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [IN_TDATA_WIDTH-1:0]             s_axis_tdata,
    // Results. tdata fields from bit 0 up: inside_res (1 bit), zeros above.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [7:0]                            m_axis_tdata,
    // Configuration write channel: register index and data.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [obpt_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]                  cfg_data
);
    import obpt_pkg::*;

    logic [3*COEF_WIDTH-1:0]  rot_row [3];
    logic [3*COORD_WIDTH-1:0] neg_center;
    logic [3*COORD_WIDTH-1:0] box_size;
    logic [TOL_WIDTH-1:0]     tolerance;

    // Valid bits of the five pipeline registers: input, product, sum, compare, output.
    logic v_in_reg,  v_in_next;
    logic v_prod_reg, v_prod_next;
    logic v_sum_reg, v_sum_next;
    logic v_cmp_reg, v_cmp_next;
    logic v_out_reg, v_out_next;

    // A stage loads when it is empty or its contents move on in the same cycle,
    // so a stall at the output backs up the pipe without losing or repeating a point.
    logic en_in, en_prod, en_sum, en_cmp, en_out;
    obpt_stage_en_t axis_en;

    logic signed [COORD_WIDTH-1:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic [2:0] axis_ok;
    logic       inside_reg;
    logic       inside_next;

    // Configuration is always accepted; the user must write it only while the pipe is idle (not enforced here).
    assign cfg_ready = 1'b1;

    obpt_cfg_regs #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH),
        .CFG_WIDTH   (CFG_WIDTH)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rot_row0   (rot_row[0]),
        .rot_row1   (rot_row[1]),
        .rot_row2   (rot_row[2]),
        .neg_center (neg_center),
        .box_size   (box_size),
        .tolerance  (tolerance)
    );

    assign en_out  = !v_out_reg  || m_axis_tready;
    assign en_cmp  = !v_cmp_reg  || en_out;
    assign en_sum  = !v_sum_reg  || en_cmp;
    assign en_prod = !v_prod_reg || en_sum;
    assign en_in   = !v_in_reg   || en_prod;

    assign s_axis_tready = en_in;

    assign axis_en.prod = en_prod;
    assign axis_en.sum  = en_sum;
    assign axis_en.cmp  = en_cmp;

    assign v_in_next   = en_in   ? s_axis_tvalid : v_in_reg;
    assign v_prod_next = en_prod ? v_in_reg      : v_prod_reg;
    assign v_sum_next  = en_sum  ? v_prod_reg    : v_sum_reg;
    assign v_cmp_next  = en_cmp  ? v_sum_reg     : v_cmp_reg;
    assign v_out_next  = en_out  ? v_cmp_reg     : v_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg   <= 1'b0;
            v_prod_reg <= 1'b0;
            v_sum_reg  <= 1'b0;
            v_cmp_reg  <= 1'b0;
            v_out_reg  <= 1'b0;
        end
        else
        begin
            v_in_reg   <= v_in_next;
            v_prod_reg <= v_prod_next;
            v_sum_reg  <= v_sum_next;
            v_cmp_reg  <= v_cmp_next;
            v_out_reg  <= v_out_next;
        end
    end

    // Input register: the point is captured on acceptance.
    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            pt_x_reg <= signed'(s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
            pt_y_reg <= signed'(s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
            pt_z_reg <= signed'(s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH]);
        end
    end

    // One datapath per box axis; axis g uses matrix row g and center, extent component g.
    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        obpt_axis #(
            .COORD_WIDTH (COORD_WIDTH),
            .COEF_WIDTH  (COEF_WIDTH)
        ) u_axis (
            .clk    (clk),
            .en     (axis_en),
            .pt_x   (pt_x_reg),
            .pt_y   (pt_y_reg),
            .pt_z   (pt_z_reg),
            .row    (rot_row[g]),
            .center (signed'(neg_center[g*COORD_WIDTH +: COORD_WIDTH])),
            .size   (box_size[g*COORD_WIDTH +: COORD_WIDTH]),
            .tol    (tolerance),
            .ok     (axis_ok[g])
        );
    end

    // Output register: the point is inside only when every axis passes.
    assign inside_next = &axis_ok;

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            inside_reg <= inside_next;
        end
    end

    assign m_axis_tvalid = v_out_reg;
    assign m_axis_tdata  = {7'b0, inside_reg};

endmodule

@@ src/obpt_cfg_regs.sv @@
// Configuration register file of the oriented box point test block.
// Depends on obpt_pkg for the register indexes and the slack width.
module obpt_cfg_regs #(
    parameter int COORD_WIDTH = 20,
    parameter int COEF_WIDTH  = 18,
    parameter int CFG_WIDTH   = 60
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    input  logic [obpt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [CFG_WIDTH-1:0]                   cfg_data,
    output logic [3*COEF_WIDTH-1:0]                rot_row0,
    output logic [3*COEF_WIDTH-1:0]                rot_row1,
    output logic [3*COEF_WIDTH-1:0]                rot_row2,
    output logic [3*COORD_WIDTH-1:0]               neg_center,
    output logic [3*COORD_WIDTH-1:0]               box_size,
    output logic [obpt_pkg::TOL_WIDTH-1:0]         tolerance
);
    import obpt_pkg::*;

    logic [3*COEF_WIDTH-1:0]  rot_row0_reg;
    logic [3*COEF_WIDTH-1:0]  rot_row1_reg;
    logic [3*COEF_WIDTH-1:0]  rot_row2_reg;
    logic [3*COORD_WIDTH-1:0] neg_center_reg;
    logic [3*COORD_WIDTH-1:0] box_size_reg;
    logic [TOL_WIDTH-1:0]     tolerance_reg;

    // Bits above each register's packed fields are dropped; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_row0_reg   <= '0;
            rot_row1_reg   <= '0;
            rot_row2_reg   <= '0;
            neg_center_reg <= '0;
            box_size_reg   <= '0;
            tolerance_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROT_ROW0:   rot_row0_reg   <= cfg_data[3*COEF_WIDTH-1:0];
                REG_ROT_ROW1:   rot_row1_reg   <= cfg_data[3*COEF_WIDTH-1:0];
                REG_ROT_ROW2:   rot_row2_reg   <= cfg_data[3*COEF_WIDTH-1:0];
                REG_NEG_CENTER: neg_center_reg <= cfg_data[3*COORD_WIDTH-1:0];
                REG_BOX_SIZE:   box_size_reg   <= cfg_data[3*COORD_WIDTH-1:0];
                REG_TOLERANCE:  tolerance_reg  <= cfg_data[TOL_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign rot_row0   = rot_row0_reg;
    assign rot_row1   = rot_row1_reg;
    assign rot_row2   = rot_row2_reg;
    assign neg_center = neg_center_reg;
    assign box_size   = box_size_reg;
    assign tolerance  = tolerance_reg;

endmodule

@@ src/obpt_axis.sv @@
// One axis of the box test: row dot point, center offset, and the two bound compares.
// Three register stages (products, sum, compare). Depends on obpt_pkg.
module obpt_axis #(
    parameter int COORD_WIDTH = 20,
    parameter int COEF_WIDTH  = 18
) (
    input  logic                                clk,
    input  obpt_pkg::obpt_stage_en_t            en,
    input  logic signed [COORD_WIDTH-1:0]       pt_x,
    input  logic signed [COORD_WIDTH-1:0]       pt_y,
    input  logic signed [COORD_WIDTH-1:0]       pt_z,
    input  logic [3*COEF_WIDTH-1:0]             row,
    input  logic signed [COORD_WIDTH-1:0]       center,
    input  logic [COORD_WIDTH-1:0]              size,
    input  logic [obpt_pkg::TOL_WIDTH-1:0]      tol,
    output logic                                ok
);
    import obpt_pkg::*;

    localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
    localparam int TRUNC_WIDTH = COORD_WIDTH + 2;
    localparam int SUM_WIDTH   = COORD_WIDTH + 4;
    localparam int CMP_WIDTH   = ((SUM_WIDTH > TOL_WIDTH + 1) ? SUM_WIDTH : TOL_WIDTH + 1) + 3;

    logic signed [COEF_WIDTH-1:0]  coef [3];
    logic signed [COORD_WIDTH-1:0] pt   [3];
    logic signed [PROD_WIDTH-1:0]  prod [3];

    logic signed [TRUNC_WIDTH-1:0] prod_reg  [3];
    logic signed [TRUNC_WIDTH-1:0] prod_next [3];
    logic signed [SUM_WIDTH-1:0]   sum_reg;
    logic signed [SUM_WIDTH-1:0]   sum_next;
    logic                          ok_reg;
    logic                          ok_next;

    logic signed [CMP_WIDTH-1:0] acc_ext;
    logic signed [CMP_WIDTH-1:0] tol_ext;
    logic signed [CMP_WIDTH-1:0] size_ext;
    logic signed [CMP_WIDTH-1:0] plus_tol;
    logic signed [CMP_WIDTH-1:0] minus_tol;
    logic signed [CMP_WIDTH-1:0] lo_margin;
    logic signed [CMP_WIDTH-1:0] hi_margin;

    assign pt[0] = pt_x;
    assign pt[1] = pt_y;
    assign pt[2] = pt_z;

    // Dropping the low fraction bits of a two's complement product floors it.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            coef[k]      = signed'(row[k*COEF_WIDTH +: COEF_WIDTH]);
            prod[k]      = PROD_WIDTH'(coef[k]) * PROD_WIDTH'(pt[k]);
            prod_next[k] = prod[k][PROD_WIDTH-1 -: TRUNC_WIDTH];
        end
    end

    assign sum_next = SUM_WIDTH'(prod_reg[0]) + SUM_WIDTH'(prod_reg[1])
                    + SUM_WIDTH'(prod_reg[2]) + SUM_WIDTH'(center);

    // Doubled bounds keep the half extent exact: -s <= 2(v+t) and 2(v-t) <= s.
    always_comb
    begin
        acc_ext   = CMP_WIDTH'(sum_reg);
        tol_ext   = signed'(CMP_WIDTH'(tol));
        size_ext  = signed'(CMP_WIDTH'(size));
        plus_tol  = acc_ext + tol_ext;
        minus_tol = acc_ext - tol_ext;
        lo_margin = (plus_tol <<< 1) + size_ext;
        hi_margin = size_ext - (minus_tol <<< 1);
        ok_next   = !lo_margin[CMP_WIDTH-1] && !hi_margin[CMP_WIDTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (en.sum)
        begin
            sum_reg <= sum_next;
        end
        if (en.cmp)
        begin
            ok_reg <= ok_next;
        end
    end

    assign ok = ok_reg;

endmodule
